// ===== src/fault_latch_with_safety_trip_top_macros.svh =====
// ----------------------------------------------------------------------------
// Fault latch assertion macros
// Shared concurrent assertion forms clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FAULT_LATCH_WITH_SAFETY_TRIP_TOP_MACROS_SVH
`define FAULT_LATCH_WITH_SAFETY_TRIP_TOP_MACROS_SVH

// Plain property check on the rising clock edge, skipped while in reset.
`define FLST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication check on the rising clock edge.
`define FLST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check on the rising clock edge.
`define FLST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/flst_pkg.sv =====
// ----------------------------------------------------------------------------
// Fault latch package
// Widths, mode codes, register indexes and limits shared by the fault latch.
// ----------------------------------------------------------------------------
`default_nettype none

package flst_pkg;

    // Number of fault sources, one bit each (1 to 32).
    localparam int NUM_SOURCES = 32;

    // Field widths.
    localparam int MODE_W   = 3;
    localparam int BITS_W   = 32;
    localparam int REASON_W = 5;
    localparam int INDEX_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Bits of source_bits that map to real sources.
    localparam logic [BITS_W-1:0] SRC_MASK =
        BITS_W'((64'd1 << NUM_SOURCES) - 64'd1);

    // Largest reason code that is stored as given.
    localparam logic [REASON_W-1:0] REASON_MAX = 5'd29;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_RAISE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR_ALL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TAKE_LOG  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING  = 2'd2;

endpackage

`default_nettype wire

// ===== src/flst_if.sv =====
// ----------------------------------------------------------------------------
// Fault latch channel interfaces
// Valid/ready channels for fault items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Fault item channel.
interface flst_item_if;
    logic                              valid;
    logic                              ready;
    logic [flst_pkg::MODE_W-1:0]       mode;
    logic [flst_pkg::BITS_W-1:0]       source_bits;
    logic [flst_pkg::REASON_W-1:0]     fault_reason;
    logic [flst_pkg::INDEX_W-1:0]      source_index;

    modport source (output valid, mode, source_bits, fault_reason, source_index,
                    input ready);
    modport sink   (input valid, mode, source_bits, fault_reason, source_index,
                    output ready);
endinterface

// Result channel.
interface flst_result_if;
    logic                              valid;
    logic                              ready;
    logic [flst_pkg::BITS_W-1:0]       active_flags;
    logic [flst_pkg::BITS_W-1:0]       logged_bits;
    logic [flst_pkg::REASON_W-1:0]     reason_out;
    logic                              critical_active;
    logic                              high_active;
    logic                              warning_active;
    logic                              shutdown_pulse;

    modport source (output valid, active_flags, logged_bits, reason_out,
                    critical_active, high_active, warning_active, shutdown_pulse,
                    input ready);
    modport sink   (input valid, active_flags, logged_bits, reason_out,
                    critical_active, high_active, warning_active, shutdown_pulse,
                    output ready);
endinterface

// Register write channel.
interface flst_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [flst_pkg::CFG_IDX_W-1:0]      index;
    logic [flst_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/fault_latch_with_safety_trip_top.sv =====
// ----------------------------------------------------------------------------
// Fault latch with safety trip
// Sticky fault mask, pending log, per-source reasons and critical shutdown.
// ----------------------------------------------------------------------------
// Usage:
//   item   : fault items in (mode, source_bits, fault_reason, source_index).
//   result : one result per item (flags, taken log, reason, severities, pulse).
//   cfg    : register writes; index 0 critical, 1 high, 2 warning mask.
//            Always ready; write only while no item is in flight.
// Latency: a result is valid the cycle after its item transfer.
// Throughput: one item per cycle while results drain. All state updates
//   and the severity and trip checks are one level of logic between the
//   fault state registers and the result register.
// Stall: the result register holds while result.ready is low, and item.ready
//   drops for as long as a result is held; a new item is taken in the same
//   cycle the held result transfers.
// Reset: masks, pending log, reasons, trip flag and severity masks go to
//   zero, and the result register empties.
// ----------------------------------------------------------------------------
`default_nettype none

module fault_latch_with_safety_trip_top
(
    input  wire                clk,
    input  wire                rst_n,
    flst_item_if.sink          item,
    flst_result_if.source      result,
    flst_cfg_if.sink           cfg
);

    // Configuration registers.
    logic [flst_pkg::BITS_W-1:0] crit_mask_reg;
    logic [flst_pkg::BITS_W-1:0] high_mask_reg;
    logic [flst_pkg::BITS_W-1:0] warn_mask_reg;

    // Fault state.
    logic [flst_pkg::BITS_W-1:0]   active_reg;
    logic [flst_pkg::BITS_W-1:0]   active_next;
    logic [flst_pkg::BITS_W-1:0]   pending_reg;
    logic [flst_pkg::BITS_W-1:0]   pending_next;
    logic                          trip_reg;
    logic                          trip_next;
    logic [flst_pkg::REASON_W-1:0] reason_reg [flst_pkg::NUM_SOURCES];

    // Result register.
    logic                          out_valid_reg;
    logic [flst_pkg::BITS_W-1:0]   out_active_reg;
    logic [flst_pkg::BITS_W-1:0]   out_logged_reg;
    logic [flst_pkg::BITS_W-1:0]   logged_next;
    logic [flst_pkg::REASON_W-1:0] out_reason_reg;
    logic [flst_pkg::REASON_W-1:0] reason_next;
    logic                          out_crit_reg;
    logic                          out_high_reg;
    logic                          out_warn_reg;
    logic                          out_pulse_reg;
    logic                          pulse_next;

    // Item decode.
    logic                          accept;
    logic [flst_pkg::BITS_W-1:0]   src_bits;
    logic [flst_pkg::BITS_W-1:0]   fresh;
    logic [flst_pkg::REASON_W-1:0] why;
    logic                          is_raise;
    logic                          is_clear_all;
    logic                          crit_next;

    // Handshakes: the item side opens whenever the result slot is free or drains.
    assign cfg.ready  = 1'b1;
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crit_mask_reg <= '0;
            high_mask_reg <= '0;
            warn_mask_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                flst_pkg::REG_CRITICAL: crit_mask_reg <= cfg.data;
                flst_pkg::REG_HIGH:     high_mask_reg <= cfg.data;
                flst_pkg::REG_WARNING:  warn_mask_reg <= cfg.data;
                default:                ;
            endcase
        end
    end

    // Operand cleanup: drop bits past the source count, out-of-range reasons read as zero.
    assign src_bits = item.source_bits & flst_pkg::SRC_MASK;
    assign why      = (item.fault_reason > flst_pkg::REASON_MAX) ? '0 : item.fault_reason;
    assign fresh    = src_bits & ~active_reg;

    // Mode decode and next fault state.
    always_comb
    begin
        active_next  = active_reg;
        pending_next = pending_reg;
        logged_next  = '0;
        reason_next  = '0;
        is_raise     = 1'b0;
        is_clear_all = 1'b0;
        unique case (item.mode)
            flst_pkg::MODE_RAISE:
            begin
                is_raise     = 1'b1;
                active_next  = active_reg | src_bits;
                pending_next = pending_reg | fresh;
            end
            flst_pkg::MODE_CLEAR:
            begin
                active_next = active_reg & ~src_bits;
            end
            flst_pkg::MODE_CLEAR_ALL:
            begin
                is_clear_all = 1'b1;
                active_next  = '0;
                pending_next = '0;
            end
            flst_pkg::MODE_TAKE_LOG:
            begin
                logged_next  = pending_reg;
                pending_next = '0;
            end
            flst_pkg::MODE_READ:
            begin
                for (int i = 0; i < flst_pkg::NUM_SOURCES; i++)
                begin
                    if (item.source_index == flst_pkg::INDEX_W'(i))
                    begin
                        reason_next = reason_reg[i];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Trip check: pulse once when a critical source becomes active while armed.
    assign crit_next  = |(active_next & crit_mask_reg);
    assign pulse_next = crit_next && (is_clear_all || !trip_reg);
    assign trip_next  = crit_next;

    // Fault state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            pending_reg <= '0;
            trip_reg    <= 1'b0;
        end
        else if (accept)
        begin
            active_reg  <= active_next;
            pending_reg <= pending_next;
            trip_reg    <= trip_next;
        end
    end

    // Reason store: newly raised sources take the reason, clear-all zeroes every entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < flst_pkg::NUM_SOURCES; i++)
            begin
                reason_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            for (int i = 0; i < flst_pkg::NUM_SOURCES; i++)
            begin
                if (is_clear_all)
                begin
                    reason_reg[i] <= '0;
                end
                else if (is_raise && fresh[i])
                begin
                    reason_reg[i] <= why;
                end
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            out_valid_reg <= item.valid;
        end
    end

    // Result payload, loaded on every item transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_active_reg <= active_next;
            out_logged_reg <= logged_next;
            out_reason_reg <= reason_next;
            out_crit_reg   <= crit_next;
            out_high_reg   <= |(active_next & high_mask_reg);
            out_warn_reg   <= |(active_next & warn_mask_reg);
            out_pulse_reg  <= pulse_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.active_flags    = out_active_reg;
    assign result.logged_bits     = out_logged_reg;
    assign result.reason_out      = out_reason_reg;
    assign result.critical_active = out_crit_reg;
    assign result.high_active     = out_high_reg;
    assign result.warning_active  = out_warn_reg;
    assign result.shutdown_pulse  = out_pulse_reg;

endmodule

`default_nettype wire

// ===== src/flst_checker.sv =====
// ----------------------------------------------------------------------------
// Fault latch port checker
// Watches the fault latch ports for stall, trip and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fault_latch_with_safety_trip_top_macros.svh"

module flst_checker
(
    input wire                              clk,
    input wire                              rst_n,
    input wire                              in_valid,
    input wire                              in_ready,
    input wire                              out_valid,
    input wire                              out_ready,
    input wire [flst_pkg::BITS_W-1:0]       active_flags,
    input wire [flst_pkg::BITS_W-1:0]       logged_bits,
    input wire [flst_pkg::REASON_W-1:0]     reason_out,
    input wire                              critical_active,
    input wire                              shutdown_pulse
);

    // Critical flag of the last result that transferred.
    logic prev_crit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_crit_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            prev_crit_reg <= critical_active;
        end
    end

    // A stalled result keeps its flags.
    `FLST_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(active_flags), "stalled result changed")

    // No item is taken while a result is held back.
    `FLST_ASSERT_IMP(a_no_take_on_stall, out_valid && !out_ready, !in_ready, "item taken while result stalled")

    // The shutdown pulse fires exactly on the first critical result after a non-critical one.
    `FLST_ASSERT_IMP(a_pulse_edge, out_valid, shutdown_pulse == (critical_active && !prev_crit_reg), "shutdown pulse mismatch")

    // A taken log and a read reason never share one result, and reasons stay in range.
    `FLST_ASSERT(a_result_shape, !out_valid || ((logged_bits == '0 || reason_out == '0) && reason_out <= flst_pkg::REASON_MAX), "inconsistent result fields")

    // Records whether any item has transferred, so a dead item channel shows in waveforms.
    logic in_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_seen_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_seen_reg <= 1'b1;
        end
    end

    // A result can only exist after some item transferred.
    `FLST_ASSERT_IMP(a_result_after_item, out_valid, in_seen_reg, "result without any item")

endmodule

bind fault_latch_with_safety_trip_top flst_checker u_flst_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (item.valid),
    .in_ready        (item.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .active_flags    (result.active_flags),
    .logged_bits     (result.logged_bits),
    .reason_out      (result.reason_out),
    .critical_active (result.critical_active),
    .shutdown_pulse  (result.shutdown_pulse)
);

`default_nettype wire

// ===== test/fault_latch_checker.sv =====
// ----------------------------------------------------------------------------
// Fault latch result checker
// Watches the item, result and register write channels of the fault latch.
// It keeps its own copy of the fault state and severity masks, works out the
// result of every item transfer, and compares each result transfer against
// the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fault_latch_checker
(
    input  wire       clk,
    input  wire       rst_n,
    flst_item_if      item,
    flst_result_if    result,
    flst_cfg_if       cfg,
    output int        mismatch_count,
    output int        results_owed
);

    // One predicted result, laid out like the result channel payload.
    typedef struct packed {
        logic [flst_pkg::BITS_W-1:0]   active_flags;
        logic [flst_pkg::BITS_W-1:0]   logged_bits;
        logic [flst_pkg::REASON_W-1:0] reason_out;
        logic                          critical_active;
        logic                          high_active;
        logic                          warning_active;
        logic                          shutdown_pulse;
    } fault_result_t;

    // Severity masks as last written.
    logic [flst_pkg::CFG_DATA_W-1:0] critical_sel;
    logic [flst_pkg::CFG_DATA_W-1:0] high_sel;
    logic [flst_pkg::CFG_DATA_W-1:0] warning_sel;

    // Predicted fault state.
    logic [flst_pkg::BITS_W-1:0]   active_set;
    logic [flst_pkg::BITS_W-1:0]   unlogged_set;
    logic [flst_pkg::REASON_W-1:0] source_reason [flst_pkg::NUM_SOURCES];
    logic                          trip_latched;

    fault_result_t predicted_results [$];
    fault_result_t oldest;
    int            k;

    // Applies one fault item to the predicted state and returns its result.
    function automatic fault_result_t apply_fault_item(
        input logic [flst_pkg::MODE_W-1:0]   mode,
        input logic [flst_pkg::BITS_W-1:0]   raw_bits,
        input logic [flst_pkg::REASON_W-1:0] raw_reason,
        input logic [flst_pkg::INDEX_W-1:0]  index
    );
        fault_result_t                 res;
        logic [flst_pkg::BITS_W-1:0]   bits;
        logic [flst_pkg::BITS_W-1:0]   fresh;
        logic [flst_pkg::REASON_W-1:0] reason;
        logic                          crit;
        int                            i;

        res    = '0;
        bits   = raw_bits & flst_pkg::SRC_MASK;
        reason = (raw_reason > flst_pkg::REASON_MAX) ? '0 : raw_reason;

        case (mode)
            flst_pkg::MODE_RAISE:
            begin
                // Only sources that were not yet active take the new reason.
                fresh        = bits & ~active_set;
                active_set   = active_set | bits;
                unlogged_set = unlogged_set | fresh;
                for (i = 0; i < flst_pkg::NUM_SOURCES; i++)
                begin
                    if (fresh[i])
                        source_reason[i] = reason;
                end
            end
            flst_pkg::MODE_CLEAR:
            begin
                active_set = active_set & ~bits;
            end
            flst_pkg::MODE_CLEAR_ALL:
            begin
                active_set   = '0;
                unlogged_set = '0;
                trip_latched = 1'b0;
                for (i = 0; i < flst_pkg::NUM_SOURCES; i++)
                    source_reason[i] = '0;
            end
            flst_pkg::MODE_TAKE_LOG:
            begin
                res.logged_bits = unlogged_set;
                unlogged_set    = '0;
            end
            flst_pkg::MODE_READ:
            begin
                if (index < flst_pkg::NUM_SOURCES)
                    res.reason_out = source_reason[index];
            end
            default:
            begin
            end
        endcase

        // The trip fires once per critical episode and re-arms when it ends.
        crit = |(active_set & critical_sel);
        if (!crit)
            trip_latched = 1'b0;
        else if (!trip_latched)
        begin
            trip_latched       = 1'b1;
            res.shutdown_pulse = 1'b1;
        end

        res.active_flags    = active_set;
        res.critical_active = crit;
        res.high_active     = |(active_set & high_sel);
        res.warning_active  = |(active_set & warning_sel);
        return res;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %h actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Track register writes, predict on item transfers, compare on result transfers.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            critical_sel = '0;
            high_sel     = '0;
            warning_sel  = '0;
            active_set   = '0;
            unlogged_set = '0;
            trip_latched = 1'b0;
            for (k = 0; k < flst_pkg::NUM_SOURCES; k++)
                source_reason[k] = '0;
            predicted_results.delete();
            results_owed = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    flst_pkg::REG_CRITICAL: critical_sel = cfg.data;
                    flst_pkg::REG_HIGH:     high_sel     = cfg.data;
                    flst_pkg::REG_WARNING:  warning_sel  = cfg.data;
                    default:
                    begin
                    end
                endcase
            end

            // The result of an earlier item is compared before this edge's item
            // is predicted, so a stray result cannot match a fresh prediction.
            if (result.valid && result.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t ns: result transfer expected none actual active_flags %h",
                             $time, result.active_flags);
                    mismatch_count++;
                end
                else
                begin
                    oldest = predicted_results.pop_front();
                    check_field("active_flags", oldest.active_flags, result.active_flags);
                    check_field("logged_bits", oldest.logged_bits, result.logged_bits);
                    check_field("reason_out", oldest.reason_out, result.reason_out);
                    check_field("critical_active", oldest.critical_active,
                                result.critical_active);
                    check_field("high_active", oldest.high_active, result.high_active);
                    check_field("warning_active", oldest.warning_active,
                                result.warning_active);
                    check_field("shutdown_pulse", oldest.shutdown_pulse,
                                result.shutdown_pulse);
                end
            end

            if (item.valid && item.ready)
                predicted_results.push_back(apply_fault_item(item.mode, item.source_bits,
                                                             item.fault_reason,
                                                             item.source_index));

            results_owed = predicted_results.size();
        end
    end

endmodule

// ===== test/tb_fault_latch_with_safety_trip_top.sv =====
// ----------------------------------------------------------------------------
// Fault latch with safety trip testbench
// Drives fault items and severity mask writes into the fault latch and stalls
// its result channel at random, including one long hold-off that backs the
// block up. A directed run covers reasons, re-raises, the trip and its re-arm,
// log taking and unused modes; random phases follow under several mask
// settings. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fault_latch_with_safety_trip_top;

    localparam int CLK_HALF        = 6;
    localparam int IDLE_LIMIT      = 5000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int SQUEEZE_CYCLES  = 300;

    // Modes that the block accepts but does nothing with.
    localparam logic [flst_pkg::MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [flst_pkg::MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatch_count;
    int   results_owed;
    int   idle_cycles = 0;
    bit   gapless = 1'b0;
    bit   squeeze_go = 1'b0;
    bit   squeeze_done = 1'b0;

    flst_item_if   item_ch ();
    flst_result_if result_ch ();
    flst_cfg_if    cfg_ch ();

    fault_latch_with_safety_trip_top i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    fault_latch_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item_ch),
        .result         (result_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always #(CLK_HALF) clk = ~clk;

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;

        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Source masks ranging from empty through single bits to dense.
    function automatic logic [flst_pkg::BITS_W-1:0] pick_sources();
        int r;

        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 15)
            return '1;
        else if (r < 45)
            return 32'h1 << $urandom_range(0, 31);
        else if (r < 70)
            return $urandom & $urandom;
        return $urandom;
    endfunction

    function automatic logic [flst_pkg::MODE_W-1:0] pick_mode();
        int r;

        r = $urandom_range(0, 99);
        if (r < 35)
            return flst_pkg::MODE_RAISE;
        else if (r < 55)
            return flst_pkg::MODE_CLEAR;
        else if (r < 59)
            return flst_pkg::MODE_CLEAR_ALL;
        else if (r < 72)
            return flst_pkg::MODE_TAKE_LOG;
        else if (r < 94)
            return flst_pkg::MODE_READ;
        return flst_pkg::MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
    endfunction

    // Offers one fault item and returns at the edge of its transfer.
    task automatic send_fault(input logic [flst_pkg::MODE_W-1:0] mode,
                              input logic [flst_pkg::BITS_W-1:0] bits,
                              input logic [flst_pkg::REASON_W-1:0] reason,
                              input logic [flst_pkg::INDEX_W-1:0] index);
        int gap;

        gap = gapless ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.mode         <= mode;
        item_ch.source_bits  <= bits;
        item_ch.fault_reason <= reason;
        item_ch.source_index <= index;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // Writes all three severity masks back to back.
    task automatic program_masks(input logic [flst_pkg::CFG_DATA_W-1:0] critical,
                                 input logic [flst_pkg::CFG_DATA_W-1:0] high,
                                 input logic [flst_pkg::CFG_DATA_W-1:0] warning);
        logic [flst_pkg::CFG_IDX_W-1:0]  regs [3];
        logic [flst_pkg::CFG_DATA_W-1:0] vals [3];
        int                              i;

        regs = '{flst_pkg::REG_CRITICAL, flst_pkg::REG_HIGH, flst_pkg::REG_WARNING};
        vals = '{critical, high, warning};
        for (i = 0; i < 3; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= regs[i];
            cfg_ch.data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Waits until every predicted result has arrived, plus the block's latency.
    task automatic settle();
        @(posedge clk);
        wait (results_owed == 0);
        repeat (3) @(posedge clk);
    endtask

    // Result side: random stalls and ready stretches, plus one long hold-off.
    initial
    begin
        int r;

        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (squeeze_go && !squeeze_done)
            begin
                result_ch.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze_done = 1'b1;
            end
            else if (r < 60)
            begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else if (r < 85)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else if (r < 95)
            begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                 || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus and verdict.
    initial
    begin
        int                              p;
        int                              n;
        logic [flst_pkg::CFG_DATA_W-1:0] crit;

        rst_n = 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.mode         <= flst_pkg::MODE_RAISE;
        item_ch.source_bits  <= '0;
        item_ch.fault_reason <= '0;
        item_ch.source_index <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= flst_pkg::REG_CRITICAL;
        cfg_ch.data          <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: low byte critical, second byte and bit 0 high, upper half warning.
        program_masks(32'h0000_00FF, 32'h0000_FF01, 32'hFFFF_0000);
        send_fault(flst_pkg::MODE_RAISE, 32'h0000_0001, 5'd5, '0);   // first critical: trip
        send_fault(flst_pkg::MODE_RAISE, 32'h0000_0003, 5'd7, '0);   // bit 0 keeps its reason
        send_fault(flst_pkg::MODE_READ, '0, '0, 5'd0);
        send_fault(flst_pkg::MODE_READ, '0, '0, 5'd1);
        send_fault(flst_pkg::MODE_RAISE, '0, 5'd9, '0);              // raise of nothing
        send_fault(flst_pkg::MODE_RAISE, 32'h8000_0000, 5'd31, '0);  // reason out of range
        send_fault(flst_pkg::MODE_RAISE, 32'h4000_0000, 5'd29, '0);
        send_fault(flst_pkg::MODE_READ, '0, '0, 5'd31);
        send_fault(flst_pkg::MODE_READ, '0, '0, 5'd30);
        send_fault(flst_pkg::MODE_TAKE_LOG, '0, '0, '0);
        send_fault(flst_pkg::MODE_TAKE_LOG, '0, '0, '0);             // log already empty
        send_fault(flst_pkg::MODE_CLEAR, '0, '0, '0);                // clear of nothing
        send_fault(flst_pkg::MODE_CLEAR, 32'h0000_0003, '0, '0);     // trip re-arms
        send_fault(flst_pkg::MODE_RAISE, 32'h0000_0004, 5'd30, '0);  // trips again
        send_fault(MODE_UNUSED_FIRST, '1, '1, '1);
        send_fault(flst_pkg::MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
                   $urandom, '0, '0);
        send_fault(MODE_UNUSED_LAST, '0, '0, '0);
        send_fault(flst_pkg::MODE_CLEAR_ALL, '0, '0, '0);            // clears and re-arms
        send_fault(flst_pkg::MODE_RAISE, '1, 5'd1, '0);
        send_fault(flst_pkg::MODE_READ, '0, '0, 5'd17);
        send_fault(flst_pkg::MODE_TAKE_LOG, '0, '0, '0);
        send_fault(flst_pkg::MODE_CLEAR, '1, '0, '0);
        send_fault(flst_pkg::MODE_RAISE, 32'h0000_0004, 5'd3, '0);
        send_fault(flst_pkg::MODE_CLEAR_ALL, '0, '0, '0);
        send_fault(flst_pkg::MODE_RAISE, 32'h0000_0004, 5'd4, '0);   // trips after clear-all
        item_ch.valid <= 1'b0;

        // Random phases, each under its own severity masks.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            case (p)
                0: program_masks('0, '0, '0);
                1: program_masks('1, '1, '1);
                2: program_masks(32'h1 << $urandom_range(0, 31), $urandom, $urandom);
                3: program_masks($urandom, $urandom, $urandom);
                4:
                begin
                    crit = (32'h1 << $urandom_range(0, 31)) | (32'h1 << $urandom_range(0, 31));
                    program_masks(crit, ~crit, $urandom & $urandom);
                end
                default: program_masks(32'h8000_0001, $urandom, '1);
            endcase
            gapless = (p == 2) || (p == 4);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Long result hold-off while items keep coming.
                if (p == 2 && n == 50)
                    squeeze_go = 1'b1;
                send_fault(pick_mode(), pick_sources(),
                           flst_pkg::REASON_W'($urandom_range(0, 31)),
                           flst_pkg::INDEX_W'($urandom_range(0, 31)));
            end
            item_ch.valid <= 1'b0;
        end

        settle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== fault_latch_with_safety_trip_top.f =====
+incdir+src
src/flst_pkg.sv
src/flst_if.sv
src/fault_latch_with_safety_trip_top.sv
src/flst_checker.sv
test/fault_latch_checker.sv
test/tb_fault_latch_with_safety_trip_top.sv
